// ----- rtl/sisbt_pkg.sv -----
// Shared types and constants for the stable insertion sort block.
package sisbt_pkg;

    localparam int KEY_W           = 48;
    localparam int ID_W            = 32;
    localparam int MAX_RECORDS_DEF = 64;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } t_rec;

    // per-cycle commands broadcast along the cell row
    typedef struct packed {
        logic ins;   // place the broadcast record
        logic pop;   // shift every entry one cell toward the head
    } t_ctl;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

endpackage

// ----- rtl/sisbt_cell.sv -----
// One position of the sorted store: holds a record and trades it with its neighbors.
module sisbt_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic            i_clk,
    input  sisbt_pkg::t_ctl i_ctl,
    input  logic [CW-1:0]   i_count,
    input  sisbt_pkg::t_rec i_new,
    input  sisbt_pkg::t_rec i_prev,
    input  logic            i_prev_gt,
    input  sisbt_pkg::t_rec i_next,
    output sisbt_pkg::t_rec o_rec,
    output logic            o_gt
);
    import sisbt_pkg::*;

    localparam logic [CW-1:0] POS = CW'(IDX);

    t_rec r_rec;
    t_rec n_rec;
    logic w_occ;
    logic w_take;

    // strict compare keeps equal keys in arrival order
    assign w_occ  = POS < i_count;
    assign o_gt   = w_occ && (r_rec.key > i_new.key);
    // this cell changes if it sits past the insertion point, or is the first free cell
    assign w_take = i_ctl.ins && (o_gt || (POS == i_count));

    always_comb begin
        n_rec = r_rec;
        if (i_ctl.pop) begin
            n_rec = i_next;
        end else if (w_take) begin
            n_rec = i_prev_gt ? i_prev : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec = r_rec;

endmodule

// ----- rtl/stable_insertion_sort_by_time_top.sv -----
// Top level of the stable insertion sort: cell row, fill count and drain control.
//
// Input channel (s_axis): one message record per transfer, reception time and
// message id in tdata, tlast set on the final record of a set. Each record is
// placed in the sorted row in the cycle it is taken, so records stream in at
// one per cycle. Equal times keep arrival order.
// When the record with tlast is taken, the block stops taking input and drains
// the row on the output channel (m_axis), one id per cycle while the receiver
// is ready, in ascending time order, starting the cycle after that transfer.
// tlast marks the final id of the run and tuser flags that records beyond
// MAX_RECORDS were dropped. On each output transfer the cell row shifts one
// entry toward its head.
// A record that arrives with the row full is discarded and only sets the flag.
// If the receiver stalls, the head id holds on m_axis and the drain waits;
// input stays blocked until the final id of the run has been taken.
// Reset empties the row and clears the flag; no clearing pass is needed.
module stable_insertion_sort_by_time_top #(
    parameter int MAX_RECORDS = sisbt_pkg::MAX_RECORDS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // [47:0] recv_time, [79:48] msg_id
    input  logic [79:0]               i_s_axis_tdata,
    input  logic                      i_s_axis_tlast,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // [31:0] sorted_id
    output logic [sisbt_pkg::ID_W-1:0] o_m_axis_tdata,
    output logic                      o_m_axis_tlast,
    // [0] dropped_some
    output logic [0:0]                o_m_axis_tuser
);
    import sisbt_pkg::*;

    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_RECORDS);
    localparam logic [CW-1:0] ONE  = CW'(1);

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_ovf;
    logic          n_ovf;

    logic w_in_xfer;
    logic w_out_xfer;
    logic w_full;
    t_ctl w_ctl;
    t_rec w_new;
    t_rec w_rec [MAX_RECORDS];
    logic w_gt  [MAX_RECORDS];

    assign w_new.key  = i_s_axis_tdata[KEY_W-1:0];
    assign w_new.id   = i_s_axis_tdata[KEY_W+ID_W-1:KEY_W];
    assign w_full     = (r_count == FULL);
    assign w_in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_xfer = o_m_axis_tvalid && i_m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FILL: begin
                if (w_in_xfer && i_s_axis_tlast) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (w_out_xfer && (r_count == ONE)) n_state = ST_FILL;
            end
            default: n_state = ST_FILL;
        endcase
    end

    // outputs and row commands
    always_comb begin
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        unique case (r_state)
            ST_FILL:  o_s_axis_tready = 1'b1;
            ST_DRAIN: o_m_axis_tvalid = 1'b1;
            default: ;
        endcase
        w_ctl.ins = w_in_xfer && !w_full;
        w_ctl.pop = w_out_xfer;
    end

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (w_ctl.ins) n_count = r_count + ONE;
        if (w_in_xfer && w_full) n_ovf = 1'b1;
        if (w_ctl.pop) begin
            n_count = r_count - ONE;
            if (r_count == ONE) n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_RECORDS; g++) begin : g_cell
            t_rec w_prev;
            logic w_prev_gt;
            t_rec w_next;
            if (g == 0) begin : g_head
                assign w_prev    = w_new;
                assign w_prev_gt = 1'b0;
            end else begin : g_body
                assign w_prev    = w_rec[g-1];
                assign w_prev_gt = w_gt[g-1];
            end
            if (g == MAX_RECORDS - 1) begin : g_tail
                assign w_next = '0;
            end else begin : g_link
                assign w_next = w_rec[g+1];
            end
            sisbt_cell #(
                .IDX (g),
                .CW  (CW)
            ) u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl),
                .i_count   (r_count),
                .i_new     (w_new),
                .i_prev    (w_prev),
                .i_prev_gt (w_prev_gt),
                .i_next    (w_next),
                .o_rec     (w_rec[g]),
                .o_gt      (w_gt[g])
            );
        end
    endgenerate

    assign o_m_axis_tdata    = w_rec[0].id;
    assign o_m_axis_tlast    = (r_count == ONE);
    assign o_m_axis_tuser[0] = r_ovf;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("fill count beyond capacity");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_count != '0))
        else $error("draining an empty row");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && o_m_axis_tlast) |=> ((r_state == ST_FILL) && (r_count == '0) && !r_ovf))
        else $error("run end did not empty the row");

    a_drop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && w_full) |=> r_ovf)
        else $error("dropped record not flagged");

    a_pop_only_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.pop |-> (!w_ctl.ins && (r_state == ST_DRAIN)))
        else $error("insert and drain overlap");

endmodule
